// ===== design/lsc_pkg.sv =====
// lsc_pkg: shared constants, types and codes for the line sensor centroid block
// used by lsc_div and line_sensor_centroid; depends on nothing else
package lsc_pkg;

  localparam int NumSensors = 6;
  localparam int SampleBits = 8;
  localparam int WeightBits = 8;
  localparam int ThreshBits = 8;
  localparam int PosBits    = 8;

  // reading sum and weighted sum widths, with headroom so they never wrap
  localparam int SumW     = SampleBits + 3;
  localparam int WsumW    = SampleBits + WeightBits + 4;
  localparam int DivSteps = WsumW;
  localparam int StepCntW = $clog2(DivSteps);
  localparam int SensIdxW = $clog2(NumSensors);
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int InDataW  = NumSensors * SampleBits;
  localparam int OutDataW = 16;

  localparam logic [ThreshBits-1:0] ThreshReset = ThreshBits'(3);
  localparam logic [WeightBits-1:0] WeightReset [NumSensors] = '{
    8'h9C, 8'hD8, 8'hEC, 8'h14, 8'h28, 8'h64
  };

  typedef enum logic [2:0] {
    REG_THRESH  = 3'd0,
    REG_WEIGHT0 = 3'd1,
    REG_WEIGHT1 = 3'd2,
    REG_WEIGHT2 = 3'd3,
    REG_WEIGHT3 = 3'd4,
    REG_WEIGHT4 = 3'd5,
    REG_WEIGHT5 = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    logic [WsumW-1:0] dividend;
    logic [SumW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WsumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/lsc_div.sv =====
// lsc_div: radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle
// depends on lsc_pkg
module lsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsc_pkg::div_req_t req_i,
  output lsc_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [lsc_pkg::StepCntW-1:0]        cnt_q, cnt_d;
  logic [lsc_pkg::SumW-1:0]            rem_q, rem_d;
  logic [lsc_pkg::SumW-1:0]            dvs_q, dvs_d;
  logic [lsc_pkg::WsumW-1:0]           quo_q, quo_d;
  logic [lsc_pkg::SumW:0]              trial;
  logic                                qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[lsc_pkg::WsumW-1]};
    qbit   = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the subtraction result fits
      if (trial >= {1'b0, dvs_q}) begin
        qbit  = 1'b1;
        rem_d = lsc_pkg::SumW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = lsc_pkg::SumW'(trial);
      end
      quo_d = {quo_q[lsc_pkg::WsumW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lsc_pkg::StepCntW'(lsc_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/line_sensor_centroid.sv =====
// line_sensor_centroid: weighted centroid of a frame of six line-sensor readings
// depends on lsc_pkg and lsc_div
//
// usage
//   s_axis carries one frame per item: six 8-bit readings, sensor 0 lowest.
//   m_axis returns one result per frame: position, line_seen, on_route, on_finish.
//   the apb port holds the detect threshold (0x00) and weights 0..5 (0x04..0x18).
//   write the registers only while no frame is in flight.
// timing
//   one multiply-accumulate a cycle over the six sensors, a set-up step,
//   then the serial divider at one quotient bit a cycle.
//   an all-zero frame skips the divider and goes from set-up straight to finish.
//   a new frame is taken only after the previous one has left the finish state.
// reset and stalls
//   reset restores the register defaults, clears the held position and empties
//   the output register. a new frame is taken while a result waits on m_axis;
//   its own result is held back until the output register is free.
module line_sensor_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sensor_0 .. sensor_5, 8 bits each, from the lowest bit up
  input  logic [lsc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // position[7:0], line_seen, on_route, on_finish, then zero fill
  output logic [lsc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsc_pkg::AddrW-1:0]     paddr,
  input  logic [lsc_pkg::DataW-1:0]     pwdata,
  output logic [lsc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  lsc_pkg::state_e                         state_q, state_d;

  logic [lsc_pkg::ThreshBits-1:0]          thresh_q;
  logic [lsc_pkg::WeightBits-1:0]          weight_q [lsc_pkg::NumSensors];
  logic [lsc_pkg::SampleBits-1:0]          samp_q   [lsc_pkg::NumSensors];
  logic [lsc_pkg::SampleBits-1:0]          samp_in  [lsc_pkg::NumSensors];
  logic [lsc_pkg::SensIdxW-1:0]            idx_q;
  logic signed [lsc_pkg::WsumW-1:0]        wsum_q;
  logic [lsc_pkg::SumW-1:0]                sum_q;
  logic                                    route_q, finish_q;
  logic [lsc_pkg::PosBits-1:0]             last_pos_q;

  logic                                    out_valid_q;
  logic [lsc_pkg::PosBits-1:0]             out_pos_q;
  logic                                    out_seen_q, out_route_q, out_finish_q;

  logic                                    accept, load_out, div_start, cfg_wr;
  logic [2:0]                              reg_idx;
  logic                                    route_in, finish_in;
  logic signed [lsc_pkg::SampleBits+lsc_pkg::WeightBits:0] prod;
  logic [lsc_pkg::WsumW-1:0]               wsum_mag;
  logic [lsc_pkg::WsumW-1:0]               quo_signed;
  logic                                    sum_zero;

  lsc_pkg::div_req_t                       div_req;
  lsc_pkg::div_rsp_t                       div_rsp;

  // ------------------------------------------------------------------ config
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lsc_pkg::REG_THRESH:  prdata = lsc_pkg::DataW'(thresh_q);
      lsc_pkg::REG_WEIGHT0,
      lsc_pkg::REG_WEIGHT1,
      lsc_pkg::REG_WEIGHT2,
      lsc_pkg::REG_WEIGHT3,
      lsc_pkg::REG_WEIGHT4,
      lsc_pkg::REG_WEIGHT5:
        prdata = {{(lsc_pkg::DataW-lsc_pkg::WeightBits){1'b0}},
                  weight_q[lsc_pkg::SensIdxW'(reg_idx - 3'(lsc_pkg::REG_WEIGHT0))]};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lsc_pkg::ThreshReset;
      for (int i = 0; i < lsc_pkg::NumSensors; i++) begin
        weight_q[i] <= lsc_pkg::WeightReset[i];
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lsc_pkg::REG_THRESH: thresh_q <= pwdata[lsc_pkg::ThreshBits-1:0];
        lsc_pkg::REG_WEIGHT0,
        lsc_pkg::REG_WEIGHT1,
        lsc_pkg::REG_WEIGHT2,
        lsc_pkg::REG_WEIGHT3,
        lsc_pkg::REG_WEIGHT4,
        lsc_pkg::REG_WEIGHT5:
          weight_q[lsc_pkg::SensIdxW'(reg_idx - 3'(lsc_pkg::REG_WEIGHT0))] <=
            pwdata[lsc_pkg::WeightBits-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------ input
  always_comb begin
    route_in = 1'b0;
    for (int i = 0; i < lsc_pkg::NumSensors; i++) begin
      samp_in[i] = s_axis_tdata[i*lsc_pkg::SampleBits +: lsc_pkg::SampleBits];
      route_in   = route_in | (samp_in[i] >= thresh_q);
    end
    // finish marker: outer sensors on the line, centre pair off it
    finish_in = (samp_in[0] >= thresh_q) && (samp_in[2] < thresh_q) &&
                (samp_in[3] < thresh_q) && (samp_in[5] >= thresh_q);
  end

  // ------------------------------------------------------------------ fsm
  assign sum_zero = (sum_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsc_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = lsc_pkg::ST_ACC;
      lsc_pkg::ST_ACC: begin
        if (idx_q == lsc_pkg::SensIdxW'(lsc_pkg::NumSensors - 1)) begin
          state_d = lsc_pkg::ST_SETUP;
        end
      end
      lsc_pkg::ST_SETUP:  state_d = sum_zero ? lsc_pkg::ST_FINISH : lsc_pkg::ST_DIV;
      lsc_pkg::ST_DIV:    if (div_rsp.done) state_d = lsc_pkg::ST_FINISH;
      lsc_pkg::ST_FINISH: if (!out_valid_q || m_axis_tready) state_d = lsc_pkg::ST_IDLE;
      default:            state_d = lsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == lsc_pkg::ST_IDLE);
    div_start     = (state_q == lsc_pkg::ST_SETUP) && !sum_zero;
    load_out      = (state_q == lsc_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------ datapath
  // shared multiply-accumulate, one sensor a cycle
  assign prod = $signed(weight_q[idx_q]) * $signed({1'b0, samp_q[idx_q]});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < lsc_pkg::NumSensors; i++) begin
        samp_q[i] <= samp_in[i];
      end
      wsum_q   <= '0;
      sum_q    <= '0;
      route_q  <= route_in;
      finish_q <= finish_in;
    end else if (state_q == lsc_pkg::ST_ACC) begin
      wsum_q <= wsum_q + lsc_pkg::WsumW'(prod);
      sum_q  <= sum_q + lsc_pkg::SumW'(samp_q[idx_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= '0;
    end else if (state_q == lsc_pkg::ST_ACC) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign wsum_mag = wsum_q[lsc_pkg::WsumW-1] ? lsc_pkg::WsumW'(-wsum_q)
                                             : lsc_pkg::WsumW'(wsum_q);

  assign div_req.start    = div_start;
  assign div_req.dividend = wsum_mag;
  assign div_req.divisor  = sum_q;

  lsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // quotient of magnitudes, sign restored so it truncates toward zero
  assign quo_signed = wsum_q[lsc_pkg::WsumW-1] ? lsc_pkg::WsumW'(-div_rsp.quotient)
                                               : div_rsp.quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (!sum_zero) last_pos_q <= quo_signed[lsc_pkg::PosBits-1:0];
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pos_q    <= sum_zero ? last_pos_q : quo_signed[lsc_pkg::PosBits-1:0];
      out_seen_q   <= !sum_zero;
      out_route_q  <= route_q;
      out_finish_q <= finish_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lsc_pkg::OutDataW-lsc_pkg::PosBits-3){1'b0}},
                          out_finish_q, out_route_q, out_seen_q, out_pos_q};

  // ------------------------------------------------------------------ checks
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == lsc_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_finish_implies_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_finish_q |-> out_route_q)
    else $error("finish marker flagged without on_route");

  a_held_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_seen_q |-> out_pos_q == last_pos_q)
    else $error("blank frame did not repeat the held position");

  a_no_div_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lsc_pkg::ST_SETUP && sum_zero |=> state_q == lsc_pkg::ST_FINISH)
    else $error("all-zero frame entered the divider");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for line_sensor_centroid; frames go in on s_axis, results are
// checked on m_axis against a local centroid predictor; registers are set over apb
// depends on lsc_pkg and the line_sensor_centroid sources
module tb;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 8;
  localparam int CycleLimit   = 3_000_000;
  localparam int SettleCycles = 40;
  localparam int RandPerPhase = 200;
  localparam int UnusedRegIdx = 7;

  typedef logic [lsc_pkg::SampleBits-1:0] reading_t;
  typedef reading_t [lsc_pkg::NumSensors-1:0] frame_t;

  // m_axis tdata layout from bit 0 up: position, line_seen, on_route, on_finish
  typedef struct packed {
    logic                               on_finish;
    logic                               on_route;
    logic                               line_seen;
    logic signed [lsc_pkg::PosBits-1:0] position;
  } centroid_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  frame_t                       s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [lsc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [lsc_pkg::AddrW-1:0]    paddr         = '0;
  logic [lsc_pkg::DataW-1:0]    pwdata        = '0;
  logic [lsc_pkg::DataW-1:0]    prdata;
  logic                         pready;

  // predictor copy of the registers and the held position
  logic [lsc_pkg::ThreshBits-1:0]        thr_cfg;
  logic signed [lsc_pkg::WeightBits-1:0] wt_cfg [lsc_pkg::NumSensors];
  logic signed [lsc_pkg::PosBits-1:0]    held_pos;

  frame_t    frame_q[$];
  centroid_t centroid_q[$];
  centroid_t got_res;
  centroid_t want_res;

  int  errors    = 0;
  int  cycle_cnt = 0;
  int  send_gap  = 0;
  int  stall_cnt = 0;
  bit  idle_on   = 1'b1;
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  line_sensor_centroid u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic centroid_t centroid_of(frame_t f);
    int rd_sum;
    int w_sum;
    int q;
    int i;
    centroid_t r;
    rd_sum = 0;
    w_sum  = 0;
    r      = '0;
    for (i = 0; i < lsc_pkg::NumSensors; i++) begin
      rd_sum += int'(f[i]);
      w_sum  += int'(wt_cfg[i]) * int'(f[i]);
      if (f[i] >= thr_cfg) r.on_route = 1'b1;
    end
    r.on_finish = f[0] >= thr_cfg && f[2] < thr_cfg && f[3] < thr_cfg && f[5] >= thr_cfg;
    // empty frame keeps the old position
    if (rd_sum != 0) begin
      q           = w_sum / rd_sum;
      held_pos    = q[lsc_pkg::PosBits-1:0];
      r.line_seen = 1'b1;
    end
    r.position = held_pos;
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // mostly no gap or a short one, now and then a long one; never a gap while idle_on is off
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 25);
    return $urandom_range(26, 120);
  endfunction

  function automatic frame_t frame_of(int a0, int a1, int a2, int a3, int a4, int a5);
    frame_t f;
    f[0] = reading_t'(a0); f[1] = reading_t'(a1); f[2] = reading_t'(a2);
    f[3] = reading_t'(a3); f[4] = reading_t'(a4); f[5] = reading_t'(a5);
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int kind;
    int c;
    int d;
    int v;
    int i;
    kind = $urandom_range(0, 9);
    c    = $urandom_range(0, lsc_pkg::NumSensors - 1);
    for (i = 0; i < lsc_pkg::NumSensors; i++) begin
      d = (i > c) ? i - c : c - i;
      case (kind)
        0: f[i] = '0;
        1, 2: begin
          // a line under the array: one bright sensor, its neighbours mixed, the rest dim
          if (d == 0) f[i] = reading_t'($urandom_range(100, 255));
          else if (d == 1) f[i] = reading_t'($urandom_range(0, 200));
          else f[i] = reading_t'($urandom_range(0, 12));
        end
        4: begin
          v = int'(thr_cfg) + int'($urandom_range(0, 2)) - 1;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          f[i] = reading_t'(v);
        end
        5: f[i] = ($urandom_range(0, 2) == 0) ? reading_t'($urandom_range(0, 255)) : '0;
        default: f[i] = reading_t'($urandom_range(0, 255));
      endcase
    end
    // finish marker: outer sensors lit, middle pair dark
    if (kind == 3) begin
      f[0] = reading_t'($urandom_range(thr_cfg, 255));
      f[5] = reading_t'($urandom_range(thr_cfg, 255));
      if (thr_cfg != 0) begin
        f[2] = reading_t'($urandom_range(0, thr_cfg - 1));
        f[3] = reading_t'($urandom_range(0, thr_cfg - 1));
      end
    end
    return f;
  endfunction

  // sender: a new item goes out once the previous one is taken and its gap has run
  always @(negedge clk_i) begin
    if (in_fire || !s_axis_tvalid) begin
      if (in_fire) send_gap = gap_len();
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (frame_q.size() != 0) begin
        s_axis_tdata  <= frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (out_fire) stall_cnt = gap_len();
    if (stall_cnt > 0) begin
      stall_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) centroid_q.push_back(centroid_of(s_axis_tdata));
  end

  always @(posedge clk_i) begin
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got_res = centroid_t'(m_axis_tdata[$bits(centroid_t)-1:0]);
      if (centroid_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got position %0d seen %0b",
                 $time, got_res.position, got_res.line_seen);
      end else begin
        want_res = centroid_q.pop_front();
        check_field("position", int'(want_res.position), int'(got_res.position));
        check_field("line_seen", int'(want_res.line_seen), int'(got_res.line_seen));
        check_field("on_route", int'(want_res.on_route), int'(got_res.on_route));
        check_field("on_finish", int'(want_res.on_finish), int'(got_res.on_finish));
        check_field("tdata fill", 0,
                    int'(m_axis_tdata[lsc_pkg::OutDataW-1:$bits(centroid_t)]));
      end
    end
  end

  task automatic apb_access(input logic wr, input int idx,
                            input logic [lsc_pkg::DataW-1:0] wdata,
                            output logic [lsc_pkg::DataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = lsc_pkg::AddrW'(idx * 4);
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_reg(input int idx, input int val);
    logic [lsc_pkg::DataW-1:0] rd;
    logic [7:0]                v8;
    v8 = 8'(val);
    // junk in the upper bits must be dropped
    apb_access(1'b1, idx, {24'($urandom()), v8}, rd);
    if (idx == lsc_pkg::REG_THRESH) thr_cfg = v8;
    else if (idx >= lsc_pkg::REG_WEIGHT0 && idx <= lsc_pkg::REG_WEIGHT5)
      wt_cfg[idx - lsc_pkg::REG_WEIGHT0] = v8;
    if (idx != UnusedRegIdx) begin
      apb_access(1'b0, idx, '0, rd);
      check_field("register readback", int'(v8), int'(rd[7:0]));
    end
  endtask

  task automatic load_config(input int thr, input int w_lo, input int w_hi);
    int i;
    set_reg(lsc_pkg::REG_THRESH, thr);
    for (i = 0; i < lsc_pkg::NumSensors; i++)
      set_reg(lsc_pkg::REG_WEIGHT0 + i, int'($urandom_range(0, w_hi - w_lo)) + w_lo);
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || s_axis_tvalid || centroid_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic feed_random(input int n);
    repeat (n) frame_q.push_back(rand_frame());
  endtask

  initial begin
    logic [lsc_pkg::DataW-1:0] rd;
    frame_t f;
    int i;
    int ph;
    thr_cfg  = lsc_pkg::ThreshReset;
    held_pos = '0;
    for (i = 0; i < lsc_pkg::NumSensors; i++) wt_cfg[i] = lsc_pkg::WeightReset[i];

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i <= lsc_pkg::NumSensors; i++) begin
      apb_access(1'b0, i, '0, rd);
      check_field("reset value",
                  int'((i == lsc_pkg::REG_THRESH) ? thr_cfg : wt_cfg[i - 1]),
                  int'(rd[7:0]));
    end

    // default registers: empty frames, lone sensors, threshold edges, rounding
    frame_q.push_back(frame_of(0, 0, 0, 0, 0, 0));
    for (i = 0; i < lsc_pkg::NumSensors; i++) begin
      f    = '0;
      f[i] = 8'hFF;
      frame_q.push_back(f);
    end
    frame_q.push_back(frame_of(0, 0, 0, 0, 0, 0));
    frame_q.push_back(frame_of(255, 255, 255, 255, 255, 255));
    frame_q.push_back(frame_of(3, 0, 2, 2, 0, 3));
    frame_q.push_back(frame_of(3, 0, 3, 2, 0, 3));
    frame_q.push_back(frame_of(2, 2, 2, 2, 2, 2));
    frame_q.push_back(frame_of(0, 0, 0, 0, 3, 0));
    frame_q.push_back(frame_of('hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55));
    frame_q.push_back(frame_of('h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA));
    frame_q.push_back(frame_of(255, 1, 0, 0, 0, 0));
    frame_q.push_back(frame_of(0, 0, 0, 0, 1, 255));
    feed_random(RandPerPhase);
    drain();

    // zero threshold, most negative weights
    load_config(0, -128, -128);
    frame_q.push_back(frame_of(0, 0, 0, 0, 0, 0));
    frame_q.push_back(frame_of(0, 0, 0, 255, 0, 0));
    frame_q.push_back(frame_of(255, 255, 255, 255, 255, 255));
    feed_random(RandPerPhase);
    drain();

    // top threshold, most positive weights
    load_config(255, 127, 127);
    frame_q.push_back(frame_of(255, 0, 254, 254, 0, 255));
    frame_q.push_back(frame_of(254, 254, 254, 254, 254, 254));
    feed_random(RandPerPhase);
    drain();

    // a write to an address with no register behind it changes nothing
    set_reg(UnusedRegIdx, int'($urandom_range(0, 255)));
    set_reg(lsc_pkg::REG_THRESH, 128);
    set_reg(lsc_pkg::REG_WEIGHT0, -128);
    set_reg(lsc_pkg::REG_WEIGHT1, 127);
    set_reg(lsc_pkg::REG_WEIGHT2, -128);
    set_reg(lsc_pkg::REG_WEIGHT3, 127);
    set_reg(lsc_pkg::REG_WEIGHT4, 0);
    set_reg(lsc_pkg::REG_WEIGHT5, 1);
    feed_random(RandPerPhase);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 1);
      load_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40),
                  -128, 127);
      feed_random(RandPerPhase);
      drain();
    end

    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t timeout after %0d cycles", $time, cycle_cnt);
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsc_pkg.sv
design/lsc_div.sv
design/line_sensor_centroid.sv
bench/tb.sv
